>>> src/u8enc_pkg.sv
// Shared types and constants for the UCS-4 to UTF-8 encoder.
// Used by the front, back, result queue and top-level modules; depends on nothing.
package u8enc_pkg;

  localparam int unsigned CpWidth    = 32;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned LenWidth   = 3;

  localparam int unsigned MidDepth   = 4;
  localparam int unsigned MidPtrW    = $clog2(MidDepth);
  localparam int unsigned MidCntW    = $clog2(MidDepth + 1);

  localparam int unsigned OutDepth   = 2;
  localparam int unsigned OutPtrW    = $clog2(OutDepth);
  localparam int unsigned OutCntW    = $clog2(OutDepth + 1);

  localparam logic [CpWidth-1:0] Lim1 = 32'h0000_0080;
  localparam logic [CpWidth-1:0] Lim2 = 32'h0000_0800;
  localparam logic [CpWidth-1:0] Lim3 = 32'h0001_0000;
  localparam logic [CpWidth-1:0] Lim4 = 32'h0020_0000;
  localparam logic [CpWidth-1:0] Lim5 = 32'h0400_0000;

  localparam logic [7:0] Prefix2 = 8'hC0;
  localparam logic [7:0] Prefix3 = 8'hE0;
  localparam logic [7:0] Prefix4 = 8'hF0;
  localparam logic [7:0] Prefix5 = 8'hF8;
  localparam logic [7:0] Prefix6 = 8'hFC;
  localparam logic [7:0] ContPrefix = 8'h80;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic                eos;
    logic [LenWidth-1:0] len;
    logic                invalid;
  } item_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  byte_valid;
    status_e               status;
    logic                  string_done;
    logic [CountWidth-1:0] byte_count;
    logic                  last;
  } result_t;

endpackage

>>> src/u8enc_front.sv
// Front end: accepts code points, classifies their encoded length and queues them.
// Depends on u8enc_pkg.
module u8enc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [31:0]               code_point_i,
  input  logic                      end_of_string_i,
  output logic                      item_valid_o,
  output u8enc_pkg::item_t          item_o,
  input  logic                      item_pop_i
);
  import u8enc_pkg::*;

  item_t               mem_q [MidDepth];
  logic [MidPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [MidPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [MidCntW-1:0]  cnt_q, cnt_d;
  logic                wr_en;
  item_t               new_item;

  always_comb begin
    new_item.code_point = code_point_i;
    new_item.eos        = end_of_string_i;
    new_item.invalid    = code_point_i[CpWidth-1];
    if (code_point_i < Lim1) begin
      new_item.len = 3'd1;
    end else if (code_point_i < Lim2) begin
      new_item.len = 3'd2;
    end else if (code_point_i < Lim3) begin
      new_item.len = 3'd3;
    end else if (code_point_i < Lim4) begin
      new_item.len = 3'd4;
    end else if (code_point_i < Lim5) begin
      new_item.len = 3'd5;
    end else begin
      new_item.len = 3'd6;
    end
  end

  assign full         = (cnt_q == MidCntW'(MidDepth));
  assign wr_en        = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + MidPtrW'(1) : wr_ptr_q;
    rd_ptr_d = item_pop_i ? rd_ptr_q + MidPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + MidCntW'(wr_en) - MidCntW'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

>>> src/u8enc_back.sv
// Back end: serializes each queued item into UTF-8 bytes and status results.
// Holds the per-string byte count and error state. Depends on u8enc_pkg.
module u8enc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [31:0]            capacity_i,
  input  logic                   item_valid_i,
  input  u8enc_pkg::item_t       item_i,
  output logic                   item_pop_o,
  output logic                   res_push_o,
  output u8enc_pkg::result_t     res_o,
  input  logic                   res_ready_i
);
  import u8enc_pkg::*;

  item_t                 cur_q;
  logic                  cur_valid_q, cur_valid_d;
  logic [LenWidth-1:0]   k_q, k_d;
  logic [CountWidth-1:0] bw_q, bw_d;
  status_e               err_q, err_d;

  logic                  has_res;
  logic                  item_end;
  logic                  clr;
  logic                  set_err;
  status_e               new_err;
  logic                  bump;
  logic                  go;
  logic                  load;
  logic [LenWidth-1:0]   r_idx;
  logic [CpWidth-1:0]    shifted;
  logic [7:0]            enc_byte;
  logic [CountWidth-1:0] bw_inc;

  assign r_idx  = cur_q.len - LenWidth'(1) - k_q;
  assign bw_inc = bw_q + CountWidth'(1);

  always_comb begin
    case (r_idx)
      3'd0:    shifted = cur_q.code_point;
      3'd1:    shifted = cur_q.code_point >> 6;
      3'd2:    shifted = cur_q.code_point >> 12;
      3'd3:    shifted = cur_q.code_point >> 18;
      3'd4:    shifted = cur_q.code_point >> 24;
      3'd5:    shifted = cur_q.code_point >> 30;
      default: shifted = '0;
    endcase
  end

  always_comb begin
    if (k_q != '0) begin
      enc_byte = ContPrefix | {2'b00, shifted[5:0]};
    end else begin
      case (cur_q.len)
        3'd1:    enc_byte = {1'b0, shifted[6:0]};
        3'd2:    enc_byte = Prefix2 | {3'b000, shifted[4:0]};
        3'd3:    enc_byte = Prefix3 | {4'b0000, shifted[3:0]};
        3'd4:    enc_byte = Prefix4 | {5'b00000, shifted[2:0]};
        3'd5:    enc_byte = Prefix5 | {6'b000000, shifted[1:0]};
        3'd6:    enc_byte = Prefix6 | {7'b0000000, shifted[0]};
        default: enc_byte = '0;
      endcase
    end
  end

  always_comb begin
    has_res          = 1'b0;
    item_end         = 1'b0;
    clr              = 1'b0;
    set_err          = 1'b0;
    new_err          = StOk;
    bump             = 1'b0;
    res_o.out_byte    = '0;
    res_o.byte_valid  = 1'b0;
    res_o.status      = StOk;
    res_o.string_done = cur_q.eos;
    res_o.byte_count  = bw_q;
    res_o.last        = 1'b1;
    if (err_q != StOk) begin
      has_res          = cur_q.eos;
      item_end         = 1'b1;
      clr              = cur_q.eos;
      res_o.status     = err_q;
    end else if (cur_q.invalid) begin
      has_res          = 1'b1;
      item_end         = 1'b1;
      clr              = cur_q.eos;
      set_err          = !cur_q.eos;
      new_err          = StInvalid;
      res_o.status     = StInvalid;
    end else if (bw_q >= capacity_i) begin
      has_res          = 1'b1;
      item_end         = 1'b1;
      clr              = cur_q.eos;
      set_err          = !cur_q.eos;
      new_err          = StFull;
      res_o.status     = StFull;
    end else begin
      has_res           = 1'b1;
      bump              = 1'b1;
      item_end          = (r_idx == '0);
      clr               = item_end && cur_q.eos;
      res_o.out_byte    = enc_byte;
      res_o.byte_valid  = 1'b1;
      res_o.string_done = item_end && cur_q.eos;
      res_o.byte_count  = bw_inc;
      res_o.last        = item_end;
    end
  end

  assign go         = cur_valid_q && (!has_res || res_ready_i);
  assign res_push_o = go && has_res;
  assign load       = item_valid_i && (!cur_valid_q || (go && item_end));
  assign item_pop_o = load;

  always_comb begin
    bw_d        = bw_q;
    err_d       = err_q;
    k_d         = k_q;
    cur_valid_d = cur_valid_q;
    if (go) begin
      k_d = item_end ? '0 : k_q + LenWidth'(1);
      if (clr) begin
        bw_d  = '0;
        err_d = StOk;
      end else begin
        if (bump) begin
          bw_d = bw_inc;
        end
        if (set_err) begin
          err_d = new_err;
        end
      end
      if (item_end) begin
        cur_valid_d = 1'b0;
      end
    end
    if (load) begin
      cur_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      k_q         <= '0;
      bw_q        <= '0;
      err_q       <= StOk;
    end else begin
      cur_valid_q <= cur_valid_d;
      k_q         <= k_d;
      bw_q        <= bw_d;
      err_q       <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= item_i;
    end
  end

endmodule

>>> src/u8enc_outq.sv
// Result queue: two-entry queue between the back end and the result ports.
// Depends on u8enc_pkg.
module u8enc_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_push_i,
  input  u8enc_pkg::result_t     res_i,
  output logic                   res_ready_o,
  output logic                   empty,
  input  logic                   pop,
  output u8enc_pkg::result_t     head_o
);
  import u8enc_pkg::*;

  result_t             mem_q [OutDepth];
  logic [OutPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [OutPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [OutCntW-1:0]  cnt_q, cnt_d;
  logic                rd_en;
  logic                full_int;

  assign empty       = (cnt_q == '0);
  assign full_int    = (cnt_q == OutCntW'(OutDepth));
  assign rd_en       = pop && !empty;
  assign res_ready_o = !full_int || rd_en;
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = res_push_i ? wr_ptr_q + OutPtrW'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + OutPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OutCntW'(res_push_i) - OutCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

>>> src/ucs4_to_utf8_encoder_unit.sv
// Top level of the UCS-4 to UTF-8 encoder: front end, back end, result queue, capacity register.
// Depends on u8enc_pkg, u8enc_front, u8enc_back and u8enc_outq.
//
//   Channel  | Handshake         | Payload
//   ---------+-------------------+--------------------------------------------------------
//   input    | push / full       | code_point_i, end_of_string_i
//   result   | empty / pop       | out_byte_o, byte_valid_o, status_o, string_done_o,
//            |                   | byte_count_o, last_o
//   config   | cfg_valid_i/ready | cfg_data_i (out_capacity)
//
// The back end emits one result per cycle unless the result queue stalls; an item encoding to
// n bytes gives n results (status-only: one, dropped: none); single-byte text runs one item
// per cycle. A four-entry item queue lets input keep flowing while long characters drain.
// After reset both queues are empty, the byte count is zero and the capacity is all ones.
// A stalled result queue stops the back end, and a full item queue raises full.
module ucs4_to_utf8_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] code_point_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic [1:0]  status_o,
  output logic        string_done_o,
  output logic [31:0] byte_count_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  import u8enc_pkg::*;

  logic [CountWidth-1:0] capacity_q;
  logic                  item_valid;
  item_t                 item;
  logic                  item_pop;
  logic                  res_push;
  result_t               res;
  logic                  res_ready;
  result_t               head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '1;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  u8enc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .code_point_i    (code_point_i),
    .end_of_string_i (end_of_string_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  u8enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .capacity_i   (capacity_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_push_o   (res_push),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  u8enc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (res_push),
    .res_i       (res),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .head_o      (head)
  );

  assign out_byte_o    = head.out_byte;
  assign byte_valid_o  = head.byte_valid;
  assign status_o      = head.status;
  assign string_done_o = head.string_done;
  assign byte_count_o  = head.byte_count;
  assign last_o        = head.last;

endmodule

>>> test/tb_ucs4_to_utf8_encoder_unit.sv
// Testbench for ucs4_to_utf8_encoder_unit: directed and random strings of code points,
// each result beat checked against an in-bench predictor of the six-byte UTF-8 encoding.
// Depends on u8enc_pkg and ucs4_to_utf8_encoder_unit, and through it on the other modules.
module tb_ucs4_to_utf8_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import u8enc_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 16;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        push            = 1'b0;
  logic        full;
  logic [31:0] code_point_i    = '0;
  logic        end_of_string_i = 1'b0;
  logic        empty;
  logic        pop             = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic [1:0]  status_o;
  logic        string_done_o;
  logic [31:0] byte_count_o;
  logic        last_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i      = '0;

  ucs4_to_utf8_encoder_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .code_point_i   (code_point_i),
    .end_of_string_i(end_of_string_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .status_o       (status_o),
    .string_done_o  (string_done_o),
    .byte_count_o   (byte_count_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [31:0] capacity_cfg  = 32'hFFFF_FFFF;
  logic [31:0] str_bytes     = '0;
  status_e     str_err       = StOk;
  result_t     utf8_exp_q[$];

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned err_count     = 0;
  int unsigned items_encoded = 0;
  int unsigned strings_sent  = 0;
  int unsigned beats_checked = 0;
  int unsigned stall_cycles  = 0;

  function automatic void add_expected(input logic [7:0] b, input logic valid,
                                       input status_e st, input logic done,
                                       input logic is_last);
    result_t r;
    r.out_byte    = b;
    r.byte_valid  = valid;
    r.status      = st;
    r.string_done = done;
    r.byte_count  = str_bytes;
    r.last        = is_last;
    utf8_exp_q.push_back(r);
  endfunction

  function automatic int predict_utf8(input logic [31:0] cp, input logic eos);
    int          n;
    int          shift;
    logic [31:0] shifted;
    logic [7:0]  lead;
    logic [7:0]  b;
    if (str_err != StOk) begin
      if (!eos) return 0;
      add_expected(8'h00, 1'b0, str_err, 1'b1, 1'b1);
      str_bytes = '0;
      str_err   = StOk;
      return 1;
    end
    if (cp >= 32'h8000_0000) begin
      add_expected(8'h00, 1'b0, StInvalid, eos, 1'b1);
      if (eos) str_bytes = '0;
      else str_err = StInvalid;
      return 1;
    end
    n = (cp < Lim1) ? 1 : (cp < Lim2) ? 2 : (cp < Lim3) ? 3 :
        (cp < Lim4) ? 4 : (cp < Lim5) ? 5 : 6;
    case (n)
      2: lead = Prefix2;
      3: lead = Prefix3;
      4: lead = Prefix4;
      5: lead = Prefix5;
      6: lead = Prefix6;
      default: lead = 8'h00;
    endcase
    for (int k = 0; k < n; k++) begin
      if (str_bytes >= capacity_cfg) begin
        add_expected(8'h00, 1'b0, StFull, eos, 1'b1);
        if (eos) str_bytes = '0;
        else str_err = StFull;
        return k + 1;
      end
      shift   = 6 * (n - 1 - k);
      shifted = cp >> shift;
      if (k != 0) b = ContPrefix | (shifted[7:0] & 8'h3F);
      else if (n == 1) b = {1'b0, cp[6:0]};
      else b = lead | (shifted[7:0] & (8'h7F >> n));
      str_bytes = str_bytes + 1;
      add_expected(b, 1'b1, StOk, (k == n - 1) && eos, k == n - 1);
    end
    if (eos) str_bytes = '0;
    return n;
  endfunction

  // Result side: check every accepted beat, then choose whether to pop next cycle.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && pop && !empty) begin
      beats_checked++;
      if (utf8_exp_q.size() == 0) begin
        $error("unexpected result beat: out_byte %h status %0d", out_byte_o, status_o);
        err_count++;
      end else begin
        e = utf8_exp_q.pop_front();
        if (e.out_byte !== out_byte_o) begin
          $error("out_byte: expected %h, got %h", e.out_byte, out_byte_o);
          err_count++;
        end
        if (e.byte_valid !== byte_valid_o) begin
          $error("byte_valid: expected %0b, got %0b", e.byte_valid, byte_valid_o);
          err_count++;
        end
        if (e.status !== status_o) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          err_count++;
        end
        if (e.string_done !== string_done_o) begin
          $error("string_done: expected %0b, got %0b", e.string_done, string_done_o);
          err_count++;
        end
        if (e.byte_count !== byte_count_o) begin
          $error("byte_count: expected %0d, got %0d", e.byte_count, byte_count_o);
          err_count++;
        end
        if (e.last !== last_o) begin
          $error("last: expected %0b, got %0b", e.last, last_o);
          err_count++;
        end
      end
    end
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Watchdog: no beat moved for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_code_point(input logic [31:0] cp, input logic eos);
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    push            <= 1'b1;
    code_point_i    <= cp;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (full);
    if (predict_utf8(cp, eos) > 0) items_encoded++;
    if (eos) strings_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (utf8_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [31:0] cap);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    capacity_cfg  = cap;
  endtask

  task automatic test_sequence_lengths();
    logic [31:0] bounds[12] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hFFFF,
                                32'h1_0000, 32'h1F_FFFF, 32'h20_0000, 32'h3FF_FFFF,
                                32'h400_0000, 32'h7FFF_FFFF};
    foreach (bounds[i]) send_code_point(bounds[i], i == 11);
    send_code_point(32'h0000_D800, 1'b1);
  endtask

  task automatic test_invalid_code_points();
    send_code_point(32'h41, 1'b0);
    send_code_point(32'h8000_0000, 1'b0);
    send_code_point(32'h42, 1'b0);
    send_code_point(32'h43, 1'b1);
    send_code_point(32'hFFFF_FFFF, 1'b1);
    send_code_point(32'h41, 1'b1);
  endtask

  task automatic test_capacity_limits();
    write_capacity(32'h0);
    send_code_point(32'h41, 1'b1);
    write_capacity(32'h2);
    send_code_point(32'h7FFF_FFFF, 1'b1);
    write_capacity(32'h3);
    send_code_point(32'h800, 1'b0);
    send_code_point(32'h41, 1'b0);
    send_code_point(32'h42, 1'b1);
    write_capacity(32'hFFFF_FFFF);
  endtask

  function automatic logic [31:0] pick_code_point();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(32'h7F, 0);
      4:       return $urandom_range(32'h7FF, 32'h80);
      5:       return $urandom_range(32'hFFFF, 32'h800);
      6:       return $urandom_range(32'h1F_FFFF, 32'h1_0000);
      7:       return $urandom_range(32'h3FF_FFFF, 32'h20_0000);
      8:       return $urandom_range(32'h7FFF_FFFF, 32'h400_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_capacity();
    case ($urandom_range(3))
      0:       return $urandom_range(16, 0);
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      default: return $urandom_range(60, 20);
    endcase
  endfunction

  task automatic test_random_strings(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned num_items);
    int unsigned start_items;
    int unsigned len;
    int unsigned strings_here;
    tx_idle_pct  = tx_pct;
    rx_idle_pct  = rx_pct;
    start_items  = items_encoded;
    strings_here = 0;
    while (items_encoded - start_items < num_items) begin
      if (strings_here % 3 == 0) write_capacity(pick_capacity());
      len = $urandom_range(6, 1);
      for (int unsigned i = 0; i < len; i++) send_code_point(pick_code_point(), i == len - 1);
      strings_here++;
    end
  endtask

  initial begin
    tx_idle_pct = 33;
    rx_idle_pct = 55;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_sequence_lengths();
    test_invalid_code_points();
    test_capacity_limits();
    test_random_strings(33, 55, 70);
    test_random_strings(55, 33, 70);
    test_random_strings(0, 0, 70);
    wait_idle();
    $display("Encoded %0d code points in %0d strings and checked %0d result beats,",
             items_encoded, strings_sent, beats_checked);
    $display("covering all six sequence lengths, invalid values and capacities 0 to max.");
    if (err_count == 0 && utf8_exp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
